@@ hw/rtl/rmic_pkg.sv @@
// Package for the row-major index converter.
// Holds field widths, register codes and the pipeline stage payload type.
// Used by row_major_index_converter; depends on nothing.
package rmic_pkg;

  localparam int AXES      = 4;
  localparam int IDX_W     = 12;
  localparam int SIZE_W    = 13;
  localparam int LIN_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_BPS   = 4;                 // quotient bits resolved per stage
  localparam int DIV_STG   = LIN_W / DIV_BPS;   // stages per division
  localparam int DIV_TOT   = DIV_STG * AXES;    // divider stages in total

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS_3 = 3'd3;

  // Action codes.
  localparam logic ACT_TO_LINEAR = 1'b0;
  localparam logic ACT_TO_MULTI  = 1'b1;

  // Payload carried by every pipeline stage.
  typedef struct packed {
    logic                        action;
    logic                        flag;
    logic [LIN_W-1:0]            work;   // dividend, quotient bits shift in below
    logic [SIZE_W-1:0]           rem;    // running remainder of the current division
    logic [AXES-1:0][IDX_W-1:0]  idx;    // input indices, then result indices
    logic [LIN_W-1:0]            lin;
  } stage_t;

endpackage

@@ hw/rtl/row_major_index_converter.sv @@
// Top level of the row-major index converter: a 49-stage pipeline.
// Depends on rmic_pkg for widths, codes and the stage payload type.
//
// Converts a four-axis coordinate to a flat row-major offset (tuser 0) or a
// flat offset back to a coordinate (tuser 1), one transfer per cycle while
// the output is not stalled and the input is not held off. Behind the input
// register lies the pipelined restoring divider, which resolves four
// quotient bits per stage, twelve stages for each of the four axis
// divisions. The whole pipeline advances together, so it holds while a
// result waits at the output. After reset and after a configuration write
// the input is held off while the stride and total-size products are
// recomputed. Write sizes only while the pipeline is empty. Out-of-range
// items raise out_of_range; the flat result is then zero and the outermost
// coordinate wraps.
module row_major_index_converter #(
  parameter int MAX_RANK = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,   // action
  input  logic [95:0]  in_tdata,   // in_index_0, in_index_1, in_index_2, in_index_3, linear_in
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // linear_out, out_index_0..3, out_of_range, zero fill
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [12:0]  cfg_data
);

  localparam int RANK = (MAX_RANK < 1) ? 1 : ((MAX_RANK > rmic_pkg::AXES) ?
                        rmic_pkg::AXES : MAX_RANK);
  localparam int NS   = rmic_pkg::DIV_TOT;   // index of the last stage

  // Configuration registers and their effective sizes.
  logic [rmic_pkg::SIZE_W-1:0] size_r [rmic_pkg::AXES];
  logic [rmic_pkg::SIZE_W-1:0] eff    [rmic_pkg::AXES];
  logic [2:0]                  settle_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rmic_pkg::AXES; i++) begin
        size_r[i] <= rmic_pkg::SIZE_W'(1);
      end
      settle_r <= 3'd4;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rmic_pkg::REG_SIZE_AXIS_0: size_r[0] <= cfg_data;
          rmic_pkg::REG_SIZE_AXIS_1: size_r[1] <= cfg_data;
          rmic_pkg::REG_SIZE_AXIS_2: size_r[2] <= cfg_data;
          rmic_pkg::REG_SIZE_AXIS_3: size_r[3] <= cfg_data;
          default: ;
        endcase
        settle_r <= 3'd4;
      end else if (settle_r != 3'd0) begin
        settle_r <= settle_r - 3'd1;
      end
    end
  end

  // Inactive outer axes and zero sizes act as size one.
  always_comb begin
    for (int i = 0; i < rmic_pkg::AXES; i++) begin
      if (i < rmic_pkg::AXES - RANK || size_r[i] == '0) begin
        eff[i] = rmic_pkg::SIZE_W'(1);
      end else begin
        eff[i] = size_r[i];
      end
    end
  end

  // Strides and total size; the total is summed from two partial products.
  logic [25:0] p32_r;
  logic [38:0] p321_r;
  logic [38:0] tot_lo_r;
  logic [25:0] tot_hi_r;
  logic [51:0] total_r;

  always_ff @(posedge clk) begin
    p32_r    <= eff[3] * eff[2];
    p321_r   <= p32_r * eff[1];
    tot_lo_r <= p321_r[25:0] * eff[0];
    tot_hi_r <= p321_r[38:26] * eff[0];
    total_r  <= 52'(tot_lo_r) + {tot_hi_r, 26'd0};
  end

  // Pipeline stages: stage 0 is the input register.
  rmic_pkg::stage_t st_r  [NS+1];
  rmic_pkg::stage_t st_nxt[NS+1];
  logic             vld_r [NS+1];
  logic             en;

  assign en        = !vld_r[NS] || out_tready;
  assign in_tready = en && (settle_r == 3'd0);

  always_comb begin
    st_nxt[0]        = '0;
    st_nxt[0].action = in_tuser;
    st_nxt[0].idx[0] = in_tdata[11:0];
    st_nxt[0].idx[1] = in_tdata[23:12];
    st_nxt[0].idx[2] = in_tdata[35:24];
    st_nxt[0].idx[3] = in_tdata[47:36];
    st_nxt[0].work   = in_tdata[95:48];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st_nxt[0];
    end
  end

  // Partial products of the flat offset, taken in step with stage 1.
  logic [11:0] prod3_r;
  logic [24:0] prod2_r;
  logic [37:0] prod1_r;
  logic [37:0] prod0lo_r;
  logic [24:0] prod0hi_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod3_r   <= st_r[0].idx[3];
      prod2_r   <= st_r[0].idx[2] * eff[3];
      prod1_r   <= st_r[0].idx[1] * p32_r;
      prod0lo_r <= st_r[0].idx[0] * p321_r[25:0];
      prod0hi_r <= st_r[0].idx[0] * p321_r[38:26];
    end
  end

  // Divider stages; stage 1 also sets the flag, stage 2 sums the offset.
  for (genvar k = 1; k <= NS; k++) begin : g_stage
    localparam int DIVN = (k - 1) / rmic_pkg::DIV_STG;
    localparam int SUB  = (k - 1) % rmic_pkg::DIV_STG;
    localparam int AX   = rmic_pkg::AXES - 1 - DIVN;

    logic [rmic_pkg::SIZE_W:0]   trial;
    logic [rmic_pkg::SIZE_W-1:0] r;
    logic [rmic_pkg::LIN_W-1:0]  w;
    logic [51:0]                 sum;

    always_comb begin
      st_nxt[k] = st_r[k-1];
      r         = (SUB == 0) ? '0 : st_r[k-1].rem;
      w         = st_r[k-1].work;
      trial     = '0;
      sum       = '0;
      // Restoring division, four quotient bits (DIV_BPS) per stage.
      for (int b = 0; b < rmic_pkg::DIV_BPS; b++) begin
        trial = {r, w[rmic_pkg::LIN_W-1]};
        w     = {w[rmic_pkg::LIN_W-2:0], 1'b0};
        if (trial >= {1'b0, eff[AX]}) begin
          trial = trial - {1'b0, eff[AX]};
          w[0]  = 1'b1;
        end
        r = trial[rmic_pkg::SIZE_W-1:0];
      end
      st_nxt[k].work = w;
      st_nxt[k].rem  = r;
      if (SUB == rmic_pkg::DIV_STG - 1) begin
        st_nxt[k].idx[AX] = r[rmic_pkg::IDX_W-1:0];
      end
      // Range check on the input indices or the input offset.
      if (k == 1) begin
        if (st_r[0].action == rmic_pkg::ACT_TO_LINEAR) begin
          st_nxt[k].flag = (13'(st_r[0].idx[0]) >= eff[0]) ||
                           (13'(st_r[0].idx[1]) >= eff[1]) ||
                           (13'(st_r[0].idx[2]) >= eff[2]) ||
                           (13'(st_r[0].idx[3]) >= eff[3]);
        end else begin
          st_nxt[k].flag = 52'(st_r[0].work) >= total_r;
        end
      end
      // Flat offset from the registered partial products.
      if (k == 2) begin
        sum = 52'(prod3_r) + 52'(prod2_r) + 52'(prod1_r) + 52'(prod0lo_r) +
              {1'b0, prod0hi_r, 26'd0};
        st_nxt[k].lin = st_r[1].flag ? '0 : sum[rmic_pkg::LIN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Result formatting: each action zeroes the fields of the other.
  logic to_multi;
  assign to_multi   = st_r[NS].action == rmic_pkg::ACT_TO_MULTI;
  assign out_tvalid = vld_r[NS];
  assign out_tdata  = {7'd0,
                       st_r[NS].flag,
                       to_multi ? st_r[NS].idx[3] : 12'd0,
                       to_multi ? st_r[NS].idx[2] : 12'd0,
                       to_multi ? st_r[NS].idx[1] : 12'd0,
                       to_multi ? st_r[NS].idx[0] : 12'd0,
                       to_multi ? 48'd0 : st_r[NS].lin};

endmodule
